// File: rtl/tilt_to_drive_command_unit_assert.svh
// Assertion macros for the tilt to drive command unit.
// Concurrent checks under simulation; empty bodies under synthesis.
`ifndef TILT_TO_DRIVE_COMMAND_UNIT_ASSERT_SVH
`define TILT_TO_DRIVE_COMMAND_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define TDC_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("tilt_to_drive_command_unit: property violated");
`define TDC_ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("tilt_to_drive_command_unit: forbidden condition");
`else
`define TDC_ASSERT(label, clk, rst, prop)
`define TDC_ASSERT_NEVER(label, clk, rst, expr)
`endif

`endif

// File: rtl/tdc_pkg.sv
// Shared types and constants of the tilt to drive command unit.
// No dependencies.
`timescale 1ns / 1ps

package tdc_pkg;

   localparam int TILT_W  = 12;
   localparam int SPEED_W = 10;
   localparam int RAD_W   = 16;
   localparam int CSR_W   = 9;
   localparam int PCT_W   = 7;
   localparam int PROD_W  = 16;

   localparam logic [TILT_W-1:0] DEAD_ZONE = 12'd200;
   localparam logic [TILT_W-1:0] FULL_SPAN = 12'd600;
   localparam logic [PCT_W-1:0]  PCT_FULL  = 7'd100;

   // f / 6 as (f * DIV6_MUL) >> DIV6_SHIFT, exact for f up to 600
   localparam logic [15:0] DIV6_MUL   = 16'd43691;
   localparam int          DIV6_SHIFT = 18;
   // n / 100 as (n * DIV100_MUL) >> DIV100_SHIFT, exact for n up to 51100
   localparam logic [17:0] DIV100_MUL   = 18'd167773;
   localparam int          DIV100_SHIFT = 24;

   localparam logic [10:0]      RADIUS_BASE   = 11'd2000;
   localparam logic [RAD_W-1:0] STRAIGHT_CODE = 16'h8000;

   localparam logic [CSR_W-1:0] MAX_SPEED_RST  = 9'd500;
   localparam logic [CSR_W-1:0] TURN_SPEED_RST = 9'd250;

   typedef enum logic [0:0] {
      CSR_MAX_SPEED  = 1'b0,
      CSR_TURN_SPEED = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [CSR_W-1:0] max_speed;
      logic [CSR_W-1:0] turn_speed;
   } csr_type;

   typedef struct packed {
      logic             neg;
      logic [PCT_W-1:0] mag;
   } pct_type;

endpackage

// File: rtl/tdc_if.sv
// Request and response channel interfaces of the tilt to drive command unit.
// Depends on tdc_pkg.
`timescale 1ns / 1ps

interface tdc_req_if
   import tdc_pkg::*;
();
   logic                     valid;
   logic                     ready;
   logic signed [TILT_W-1:0] x_tilt;
   logic signed [TILT_W-1:0] y_tilt;

   modport source (output valid, output x_tilt, output y_tilt, input ready);
   modport sink   (input valid, input x_tilt, input y_tilt, output ready);
endinterface

interface tdc_rsp_if
   import tdc_pkg::*;
();
   logic                      valid;
   logic                      ready;
   logic signed [SPEED_W-1:0] speed;
   logic signed [RAD_W-1:0]   radius;

   modport source (output valid, output speed, output radius, input ready);
   modport sink   (input valid, input speed, input radius, output ready);
endinterface

// File: rtl/tdc_csr.sv
// Configuration registers: max_speed and turn_speed.
// Depends on tdc_pkg.
`timescale 1ns / 1ps

module tdc_csr
   import tdc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_we,
   input  csr_index_type    csr_index,
   input  logic [CSR_W-1:0] csr_wdata,
   output csr_type          csr
);

   csr_type csr_ff;
   csr_type csr_in;

   always_comb begin
      csr_in = csr_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_MAX_SPEED:  csr_in.max_speed  = csr_wdata;
            CSR_TURN_SPEED: csr_in.turn_speed = csr_wdata;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.max_speed  <= MAX_SPEED_RST;
         csr_ff.turn_speed <= TURN_SPEED_RST;
      end else begin
         csr_ff <= csr_in;
      end
   end

   assign csr = csr_ff;

endmodule

// File: rtl/tdc_axis.sv
// One tilt axis to a signed percent: dead zone, clamp, divide by six.
// Depends on tdc_pkg.
`timescale 1ns / 1ps

module tdc_axis
   import tdc_pkg::*;
(
   input  logic signed [TILT_W-1:0] tilt,
   output pct_type                  pct
);

   logic [TILT_W-1:0] mag_abs;
   logic [TILT_W-1:0] excess;
   logic [25:0]       quot_prod;

   always_comb begin
      mag_abs   = tilt[TILT_W-1] ? TILT_W'(-tilt) : TILT_W'(tilt);
      excess    = mag_abs - DEAD_ZONE;
      quot_prod = 26'(excess[9:0]) * 26'(DIV6_MUL);
      pct.neg   = tilt[TILT_W-1];
      priority if (mag_abs < DEAD_ZONE) begin
         pct.mag = '0;
      end else if (excess > FULL_SPAN) begin
         pct.mag = PCT_FULL;
      end else begin
         pct.mag = quot_prod[DIV6_SHIFT +: PCT_W];
      end
   end

endmodule

// File: rtl/tdc_cmd.sv
// Final command stage: divide speed product by 100, select radius and speed.
// Depends on tdc_pkg.
`timescale 1ns / 1ps

module tdc_cmd
   import tdc_pkg::*;
(
   input  logic [PROD_W-1:0]         prod,
   input  logic                      x_neg,
   input  pct_type                   y_pct,
   input  csr_type                   csr,
   output logic signed [SPEED_W-1:0] speed,
   output logic signed [RAD_W-1:0]   radius
);

   logic [33:0]        quot_prod;
   logic [CSR_W-1:0]   quot;
   logic [SPEED_W-1:0] quot_ext;
   logic [SPEED_W-1:0] x_speed;
   logic [SPEED_W-1:0] turn_ext;
   logic [10:0]        rad_mag;
   logic [RAD_W-1:0]   rad_ext;

   always_comb begin
      quot_prod = 34'(prod) * 34'(DIV100_MUL);
      quot      = quot_prod[DIV100_SHIFT +: CSR_W];
      quot_ext  = {1'b0, quot};
      x_speed   = x_neg ? SPEED_W'(-quot_ext) : quot_ext;
      turn_ext  = {1'b0, csr.turn_speed};
      rad_mag   = RADIUS_BASE - (11'(y_pct.mag) << 4) - (11'(y_pct.mag) << 2);
      rad_ext   = {5'd0, rad_mag};
      priority if (y_pct.mag == '0) begin
         speed  = x_speed;
         radius = STRAIGHT_CODE;
      end else if (y_pct.mag == PCT_FULL) begin
         speed  = y_pct.neg ? SPEED_W'(-turn_ext) : turn_ext;
         radius = '0;
      end else begin
         speed  = x_speed;
         radius = y_pct.neg ? RAD_W'(-rad_ext) : rad_ext;
      end
   end

endmodule

// File: rtl/tilt_to_drive_command_unit.sv
// Tilt to drive command unit: four register stages (input, percent, product,
// result). An accepted req beat passes all four to reach rsp; one beat per cycle is
// sustained with no rsp stall, set by one multiplier between each register pair.
// A stall on rsp backs up stage by stage; req.ready drops only when all are full.
// Synchronous reset clears all stage valids and loads max_speed 500, turn_speed 250.
`timescale 1ns / 1ps
`include "tilt_to_drive_command_unit_assert.svh"

module tilt_to_drive_command_unit
   import tdc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   tdc_req_if.sink          req,
   tdc_rsp_if.source        rsp,
   input  logic             csr_we,
   input  csr_index_type    csr_index,
   input  logic [CSR_W-1:0] csr_wdata
);

   csr_type csr;

   logic s0_valid_ff, s1_valid_ff, s2_valid_ff, out_valid_ff;
   logic s0_adv, s1_adv, s2_adv, out_adv;

   logic signed [TILT_W-1:0] s0_x_ff, s0_y_ff;
   pct_type                  x_pct_in, y_pct_in;
   pct_type                  s1_x_ff, s1_y_ff;
   logic [PROD_W-1:0]        prod_in;
   logic [PROD_W-1:0]        s2_prod_ff;
   logic                     s2_x_neg_ff;
   pct_type                  s2_y_ff;
   logic signed [SPEED_W-1:0] speed_in, speed_ff;
   logic signed [RAD_W-1:0]   radius_in, radius_ff;

   tdc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .csr       (csr)
   );

   tdc_axis u_axis_x (.tilt(s0_x_ff), .pct(x_pct_in));
   tdc_axis u_axis_y (.tilt(s0_y_ff), .pct(y_pct_in));

   assign prod_in = PROD_W'(s1_x_ff.mag) * PROD_W'(csr.max_speed);

   tdc_cmd u_cmd (
      .prod   (s2_prod_ff),
      .x_neg  (s2_x_neg_ff),
      .y_pct  (s2_y_ff),
      .csr    (csr),
      .speed  (speed_in),
      .radius (radius_in)
   );

   assign out_adv   = !out_valid_ff || rsp.ready;
   assign s2_adv    = !s2_valid_ff || out_adv;
   assign s1_adv    = !s1_valid_ff || s2_adv;
   assign s0_adv    = !s0_valid_ff || s1_adv;
   assign req.ready = s0_adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff  <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (s0_adv)  s0_valid_ff  <= req.valid;
         if (s1_adv)  s1_valid_ff  <= s0_valid_ff;
         if (s2_adv)  s2_valid_ff  <= s1_valid_ff;
         if (out_adv) out_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s0_adv) begin
         s0_x_ff <= req.x_tilt;
         s0_y_ff <= req.y_tilt;
      end
      if (s1_adv) begin
         s1_x_ff <= x_pct_in;
         s1_y_ff <= y_pct_in;
      end
      if (s2_adv) begin
         s2_prod_ff  <= prod_in;
         s2_x_neg_ff <= s1_x_ff.neg;
         s2_y_ff     <= s1_y_ff;
      end
      if (out_adv) begin
         speed_ff  <= speed_in;
         radius_ff <= radius_in;
      end
   end

   assign rsp.valid  = out_valid_ff;
   assign rsp.speed  = speed_ff;
   assign rsp.radius = radius_ff;

   `TDC_ASSERT(a_out_from_s2, clock, reset, $rose(out_valid_ff) |-> $past(s2_valid_ff))
   `TDC_ASSERT_NEVER(a_pct_range, clock, reset, s1_valid_ff && (s1_x_ff.mag > PCT_FULL || s1_y_ff.mag > PCT_FULL))
   `TDC_ASSERT(a_radius_step, clock, reset, (out_valid_ff && radius_ff != '0 && radius_ff != STRAIGHT_CODE) |-> (radius_ff[1:0] == 2'b00))

endmodule
